// File: design/clsr_pkg.sv
// ----------------------------------------------------------------------------
// clsr_pkg
// Types, constants and arithmetic helpers of the combined LCG shuffle generator.
// ----------------------------------------------------------------------------
package clsr_pkg;

  // shuffle table depth (1..64)
  localparam int TABLE_DEPTH = 32;
  localparam int WARMUP      = 8;
  localparam int SEED_STEPS  = TABLE_DEPTH + WARMUP;

  localparam int DW     = 31;                 // state / deviate width
  localparam int MUL_W  = 16;                 // multiplier constant width
  localparam int PROD_W = DW + MUL_W;         // exact product width
  localparam int FOLD_W = 8;                  // 2^31 - modulus fits in 8 bits
  localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(SEED_STEPS);
  localparam int QW     = $clog2(TABLE_DEPTH) + 1;

  // command codes
  localparam logic CMD_NEXT   = 1'b0;
  localparam logic CMD_RESEED = 1'b1;

  localparam logic [DW:0]      MOD_ONE  = 32'd2147483563;
  localparam logic [DW:0]      MOD_TWO  = 32'd2147483399;
  localparam logic [MUL_W-1:0] MUL_ONE  = 16'd40014;
  localparam logic [MUL_W-1:0] MUL_TWO  = 16'd40692;
  localparam logic [DW-1:0]    TOP_DEV  = 31'd2147483562;
  localparam logic [DW-1:0]    Y_RESET  = 31'd123456789;

  // 2^31 is congruent to these values modulo each modulus
  localparam logic [FOLD_W-1:0] FOLD_ONE = FOLD_W'((64'd1 << DW) - 64'(MOD_ONE));
  localparam logic [FOLD_W-1:0] FOLD_TWO = FOLD_W'((64'd1 << DW) - 64'(MOD_TWO));

  // slot = deviate / SLOT_SPAN, done as reciprocal multiply plus one correction
  localparam longint unsigned SLOT_SPAN = 64'd1 + 64'(TOP_DEV) / 64'(TABLE_DEPTH);
  localparam longint unsigned RECIP     = (64'd1 << DW) / SLOT_SPAN;
  localparam int              RECIP_W   = (RECIP > 0) ? $clog2(RECIP + 1) : 1;
  localparam logic [DW-1:0]   SPAN_V    = DW'(SLOT_SPAN);
  localparam logic [RECIP_W-1:0] RECIP_V = RECIP_W'(RECIP);

  typedef struct packed {
    logic load_seed;   // load both generators from the seed
    logic prod_en;     // register the generator products
    logic seed_red;    // finish one warm-up / table-fill step
    logic next_red;    // finish both generator steps, resolve slot
    logic tab_rd;      // read the selected table entry
    logic finish;      // form deviate, refill slot, present result
  } clsr_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic out_free;
  } clsr_stat_t;

  // p mod m for p < 2^47 and m = 2^31 - f: one fold and one conditional subtract
  function automatic logic [DW-1:0] fold_mod(input logic [PROD_W-1:0] p,
                                             input logic [DW:0]       m,
                                             input logic [FOLD_W-1:0] f);
    logic [MUL_W+FOLD_W-1:0] hf;
    logic [DW:0]             s;
    hf = {{FOLD_W{1'b0}}, p[PROD_W-1:DW]} * {{MUL_W{1'b0}}, f};
    s  = {1'b0, p[DW-1:0]} + (DW+1)'(hf);
    if (s >= m) begin
      s = s - m;
    end
    return s[DW-1:0];
  endfunction

endpackage

// File: design/clsr_in_if.sv
// ----------------------------------------------------------------------------
// clsr_in_if
// Command channel: valid/ready with command and seed payload.
// ----------------------------------------------------------------------------
interface clsr_in_if;
  import clsr_pkg::*;

  logic          valid;
  logic          ready;
  logic          command;
  logic [DW-1:0] seed_magnitude;

  modport source (output valid, command, seed_magnitude, input ready);
  modport sink   (input valid, command, seed_magnitude, output ready);
endinterface

// File: design/clsr_out_if.sv
// ----------------------------------------------------------------------------
// clsr_out_if
// Result channel: valid/ready with the integer deviate.
// ----------------------------------------------------------------------------
interface clsr_out_if;
  import clsr_pkg::*;

  logic          valid;
  logic          ready;
  logic [DW-1:0] deviate;

  modport source (output valid, deviate, input ready);
  modport sink   (input valid, deviate, output ready);
endinterface

// File: design/combined_lcg_shuffle_rng.sv
// ----------------------------------------------------------------------------
// combined_lcg_shuffle_rng
// Combined two-modulus multiplicative congruential generator with a
// 32-entry shuffle table; one integer deviate per command.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : valid/ready command channel. command 0 asks for the next
//              deviate, command 1 reseeds from seed_magnitude (0 acts as 1)
//              and then returns a deviate.
//   out_chan : valid/ready result channel, one deviate per command in
//              1..2147483562; the fraction is deviate / 2147483563.
// Timing:
//   A next-deviate command runs through S_NEXT_MUL, S_NEXT_RED, S_NEXT_RD and
//   S_NEXT_WB; no new command is taken before S_IDLE. A reseed first runs 40
//   warm-up steps through the shared multiply/fold unit (register the exact
//   product, then fold and subtract). The table read and refill use their own
//   states on a RAM with one write port and one read port.
//   The result sits in an output register; the next command is taken while
//   it waits. If the receiver still stalls when the following result is
//   ready, the sequencer holds until the output register frees up.
// Reset: generator states go to 1 and 123456789, the previous deviate to 0
//   and every table entry reads as zero; no result is pending.
// ----------------------------------------------------------------------------
module combined_lcg_shuffle_rng (
  input  logic              clk,
  input  logic              rst_n,
  clsr_in_if.sink           in_chan,
  clsr_out_if.source        out_chan
);
  import clsr_pkg::*;

  clsr_cmd_t  cmd;
  clsr_stat_t stat;

  clsr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_command (in_chan.command),
    .in_ready   (in_chan.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  clsr_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .seed      (in_chan.seed_magnitude),
    .stat      (stat),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .deviate   (out_chan.deviate)
  );
endmodule

// File: design/clsr_ram.sv
// ----------------------------------------------------------------------------
// clsr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// File: design/clsr_ctrl.sv
// ----------------------------------------------------------------------------
// clsr_ctrl
// Sequencer: accepts a command, runs warm-up steps on reseed, then one
// generator step, table read and table refill per deviate.
// ----------------------------------------------------------------------------
module clsr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_command,
  output logic                  in_ready,
  input  clsr_pkg::clsr_stat_t  stat,
  output clsr_pkg::clsr_cmd_t   cmd
);
  import clsr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_SEED_MUL = 7'b0000010,
    S_SEED_RED = 7'b0000100,
    S_NEXT_MUL = 7'b0001000,
    S_NEXT_RED = 7'b0010000,
    S_NEXT_RD  = 7'b0100000,
    S_NEXT_WB  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command == CMD_RESEED) begin
            cmd.load_seed = 1'b1;
            state_nxt     = S_SEED_MUL;
          end else begin
            state_nxt = S_NEXT_MUL;
          end
        end
      end
      S_SEED_MUL: begin
        cmd.prod_en = 1'b1;
        state_nxt   = S_SEED_RED;
      end
      S_SEED_RED: begin
        cmd.seed_red = 1'b1;
        state_nxt    = stat.count_zero ? S_NEXT_MUL : S_SEED_MUL;
      end
      S_NEXT_MUL: begin
        cmd.prod_en = 1'b1;
        state_nxt   = S_NEXT_RED;
      end
      S_NEXT_RED: begin
        cmd.next_red = 1'b1;
        state_nxt    = S_NEXT_RD;
      end
      S_NEXT_RD: begin
        cmd.tab_rd = 1'b1;
        state_nxt  = S_NEXT_WB;
      end
      S_NEXT_WB: begin
        // hold here while the previous result is still waiting
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end
endmodule

// File: design/clsr_dp.sv
// ----------------------------------------------------------------------------
// clsr_dp
// Datapath: both generator states, shared multiply/fold step, slot
// selection, shuffle table and the result register.
// ----------------------------------------------------------------------------
module clsr_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  clsr_pkg::clsr_cmd_t          cmd,
  input  logic [clsr_pkg::DW-1:0]      seed,
  output clsr_pkg::clsr_stat_t         stat,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [clsr_pkg::DW-1:0]      deviate
);
  import clsr_pkg::*;

  logic [DW-1:0]          x_r, x_nxt, y_r, y_nxt, last_r, last_nxt;
  logic [PROD_W-1:0]      prod_x_r, prod_y_r;
  logic [QW-1:0]          q0_r;
  logic [RECIP_W+DW-1:0]  qprod;
  logic [SLOT_W-1:0]      slot_r, slot_nxt;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [TABLE_DEPTH-1:0] vld_r, vld_nxt;
  logic                   ent_vld_r;
  logic                   out_valid_r;
  logic [DW-1:0]          dev_r;

  logic [DW-1:0]     red_x, red_y, seed_eff, qspan, rem, entry, dev_nxt;
  logic [QW:0]       q_inc;
  logic [DW+1:0]     diff, diff_adj;
  logic              fill_now;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [DW-1:0]     ram_rdata;

  assign red_x    = fold_mod(prod_x_r, MOD_ONE, FOLD_ONE);
  assign red_y    = fold_mod(prod_y_r, MOD_TWO, FOLD_TWO);
  assign seed_eff = (seed == '0) ? DW'(1) : seed;
  assign qprod    = RECIP_V * last_r;

  // slot correction: the reciprocal estimate is at most one low
  assign qspan = DW'(q0_r) * SPAN_V;
  assign rem   = last_r - qspan;
  assign q_inc = {1'b0, q0_r} + (QW+1)'(rem >= SPAN_V);

  always_comb begin
    if (q_inc >= (QW+1)'(TABLE_DEPTH)) begin
      slot_nxt = SLOT_W'(TABLE_DEPTH - 1);
    end else begin
      slot_nxt = q_inc[SLOT_W-1:0];
    end
  end

  assign fill_now = cmd.seed_red && (cnt_r < CNT_W'(TABLE_DEPTH));
  assign entry    = ent_vld_r ? ram_rdata : '0;
  assign diff     = {2'b00, entry} - {2'b00, y_r};
  assign diff_adj = (diff[DW+1] || (diff == '0)) ? diff + (DW+2)'(TOP_DEV) : diff;
  assign dev_nxt  = diff_adj[DW-1:0];

  always_comb begin
    x_nxt    = x_r;
    y_nxt    = y_r;
    last_nxt = last_r;
    cnt_nxt  = cnt_r;
    vld_nxt  = vld_r;
    if (cmd.load_seed) begin
      x_nxt   = seed_eff;
      y_nxt   = seed_eff;
      cnt_nxt = CNT_W'(SEED_STEPS - 1);
    end
    if (cmd.seed_red) begin
      x_nxt = red_x;
      if (cnt_r == '0) begin
        last_nxt = red_x;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end
    if (fill_now) begin
      vld_nxt[cnt_r[SLOT_W-1:0]] = 1'b1;
    end
    if (cmd.next_red) begin
      x_nxt = red_x;
      y_nxt = red_y;
    end
    if (cmd.finish) begin
      last_nxt        = dev_nxt;
      vld_nxt[slot_r] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r         <= DW'(1);
      y_r         <= Y_RESET;
      last_r      <= '0;
      cnt_r       <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      x_r    <= x_nxt;
      y_r    <= y_nxt;
      last_r <= last_nxt;
      cnt_r  <= cnt_nxt;
      vld_r  <= vld_nxt;
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prod_en) begin
      prod_x_r <= MUL_ONE * x_r;
      prod_y_r <= MUL_TWO * y_r;
      q0_r     <= QW'(qprod >> DW);
    end
    if (cmd.next_red) begin
      slot_r <= slot_nxt;
    end
    if (cmd.tab_rd) begin
      ent_vld_r <= vld_r[slot_r];
    end
    if (cmd.finish) begin
      dev_r <= dev_nxt;
    end
  end

  assign ram_we    = fill_now || cmd.finish;
  assign ram_waddr = cmd.finish ? slot_r : cnt_r[SLOT_W-1:0];

  clsr_ram #(
    .WIDTH (DW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (cmd.finish ? x_r : red_x),
    .re    (cmd.tab_rd),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  assign stat.count_zero = (cnt_r == '0);
  assign stat.out_free   = !out_valid_r || out_ready;
  assign out_valid       = out_valid_r;
  assign deviate         = dev_r;
endmodule

// File: design/clsr_checker.sv
// ----------------------------------------------------------------------------
// clsr_checker
// Port-level checks of the generator, bound to the top level.
// ----------------------------------------------------------------------------
module clsr_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    in_command,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [clsr_pkg::DW-1:0] out_deviate
);
  import clsr_pkg::*;

  // deviate never leaves 1..TOP_DEV
  a_dev_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_deviate != '0) && (out_deviate <= TOP_DEV))
    else $error("deviate out of range");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

  // one command in flight at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second command taken while busy");

  // a taken next-deviate command must bring its result to out_valid
  a_next_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_command == CMD_NEXT)) |-> ##5 out_valid)
    else $error("next-deviate result late");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_deviate))
    else $error("stalled result changed");
endmodule

bind combined_lcg_shuffle_rng clsr_checker u_clsr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_chan.valid),
  .in_ready    (in_chan.ready),
  .in_command  (in_chan.command),
  .out_valid   (out_chan.valid),
  .out_ready   (out_chan.ready),
  .out_deviate (out_chan.deviate)
);
